@@ hw/rtl/memory_lcd_frame_serializer_core_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef MEMORY_LCD_FRAME_SERIALIZER_CORE_DEFINES_SVH
`define MEMORY_LCD_FRAME_SERIALIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MLFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MLFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mlfs_pkg.sv @@
`timescale 1ns / 1ps
package mlfs_pkg;

    localparam int MAX_WIDTH        = 128;
    localparam int MAX_HEIGHT       = 128;
    localparam int STORE_LINE_BYTES = MAX_WIDTH / 8;
    localparam int STORE_BYTES      = STORE_LINE_BYTES * MAX_HEIGHT;
    localparam int ADDR_W           = $clog2(STORE_BYTES);
    localparam int LB_W             = $clog2(STORE_LINE_BYTES + 1);
    localparam int LINE_W           = 8;
    localparam int ROW_W            = $clog2(MAX_HEIGHT);

    localparam logic [7:0] CMD_WRITE  = 8'h01;
    localparam logic [7:0] CMD_VCOM   = 8'h02;
    localparam logic [7:0] CMD_CLEAR  = 8'h04;
    localparam logic [7:0] BLANK_BYTE = 8'hFF;

    localparam logic REG_LINE_BYTES = 1'b0;
    localparam logic REG_LINE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        MODE_PIXEL  = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_TOGGLE = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t             op;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
        logic              on;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       rel;
        logic       last;
    } res_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_CMD,
        ST_CMD_END,
        ST_HEAD,
        ST_NUM,
        ST_DATA,
        ST_TRAIL,
        ST_FINAL
    } back_state_t;

endpackage

@@ hw/rtl/mlfs_front.sv @@
`timescale 1ns / 1ps
module mlfs_front (
    input  logic                        push,
    input  logic [1:0]                  mode,
    input  logic [8:0]                  x_pos,
    input  logic [7:0]                  y_pos,
    input  logic                        pixel_on,
    input  logic [mlfs_pkg::LB_W-1:0]   lb_eff,
    input  logic [mlfs_pkg::LINE_W-1:0] lc_eff,
    input  logic                        stop,
    output logic                        q_push,
    output mlfs_pkg::cmd_t              q_data
);
    import mlfs_pkg::*;

    logic [8:0]                  x_limit;
    logic                        in_range;
    logic [ROW_W+LB_W-1:0]       row_base;
    logic [ROW_W+LB_W-1:0]       addr_full;

    assign x_limit   = {1'b0, lb_eff, 3'b000};
    assign in_range  = (x_pos < x_limit) && (y_pos < lc_eff);
    assign row_base  = y_pos[ROW_W-1:0] * lb_eff;
    assign addr_full = row_base + (ROW_W+LB_W)'(x_pos[8:3]);

    always_comb
    begin
        q_data.op      = mode_t'(mode);
        q_data.addr    = addr_full[ADDR_W-1:0];
        q_data.bit_sel = x_pos[2:0];
        q_data.on      = pixel_on;
    end

    // drop out-of-range pixels at the door
    assign q_push = push && !stop && ((mode_t'(mode) != MODE_PIXEL) || in_range);

endmodule

@@ hw/rtl/mlfs_cmd_queue.sv @@
`timescale 1ns / 1ps
module mlfs_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  mlfs_pkg::cmd_t wr_data,
    input  logic           rd_en,
    output mlfs_pkg::cmd_t rd_data,
    output logic           q_full,
    output logic           q_empty
);
    import mlfs_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/mlfs_res_fifo.sv @@
`timescale 1ns / 1ps
module mlfs_res_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  mlfs_pkg::res_t wr_data,
    input  logic           rd_en,
    output mlfs_pkg::res_t rd_data,
    output logic           f_full,
    output logic           f_empty
);
    import mlfs_pkg::*;

    res_t       slot_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign f_full  = (count_reg == 3'd4);
    assign f_empty = (count_reg == 3'd0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !f_full;
    assign do_rd   = rd_en && !f_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 2'(do_wr);
        rd_ptr_next = rd_ptr_reg + 2'(do_rd);
        count_next  = count_reg + 3'(do_wr) - 3'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/mlfs_back.sv @@
`timescale 1ns / 1ps
module mlfs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mlfs_pkg::LB_W-1:0]   lb_eff,
    input  logic [mlfs_pkg::LINE_W-1:0] lc_eff,
    input  mlfs_pkg::cmd_t              q_head,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic                        res_full,
    output logic                        res_push,
    output mlfs_pkg::res_t              res_entry,
    output logic                        init_busy
);
    import mlfs_pkg::*;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [7:0]          mem [STORE_BYTES];
    logic [7:0]          rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [7:0]          mem_wdata;

    logic                init_reg;
    logic                init_next;
    logic [ADDR_W-1:0]   sweep_cnt_reg;
    logic [ADDR_W-1:0]   sweep_cnt_next;
    logic                pol_reg;
    logic                pol_next;
    logic [LINE_W-1:0]   next_line_reg;
    logic [LINE_W-1:0]   next_line_next;
    logic [LINE_W-1:0]   line_reg;
    logic [LINE_W-1:0]   line_next;
    logic [LB_W-1:0]     rd_cnt_reg;
    logic [LB_W-1:0]     rd_cnt_next;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [ADDR_W-1:0]   rd_addr_next;
    logic                pend_reg;
    logic                pend_next;
    logic                clear_reg;
    logic                clear_next;
    logic [7:0]          cmd_byte_reg;
    logic [7:0]          cmd_byte_next;
    cmd_t                pix_reg;
    cmd_t                pix_next;

    logic                sweep_done;
    logic                data_go;
    logic                last_line;
    logic [LINE_W-1:0]   start_line;
    logic [ROW_W+LB_W-1:0] line_base;
    logic [7:0]          bit_mask;

    assign init_busy  = init_reg;
    assign sweep_done = (sweep_cnt_reg == {ADDR_W{1'b1}});
    assign data_go    = !pend_reg || !res_full;
    assign last_line  = ({1'b0, line_reg} + 9'd1) >= {1'b0, lc_eff};
    assign start_line = (next_line_reg >= lc_eff) ? '0 : next_line_reg;
    assign line_base  = line_reg[ROW_W-1:0] * lb_eff;
    assign bit_mask   = 8'b1 << pix_reg.bit_sel;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.op)
                        MODE_PIXEL:  state_next = ST_PIX_RD;
                        MODE_CLEAR:  state_next = ST_CMD;
                        MODE_TOGGLE: state_next = ST_CMD;
                        MODE_DRAW:   state_next = (start_line == '0) ? ST_HEAD : ST_NUM;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_RD:  state_next = ST_PIX_WR;
            ST_PIX_WR:  state_next = ST_IDLE;
            ST_CMD:
            begin
                if (!res_full)
                begin
                    state_next = ST_CMD_END;
                end
            end
            ST_CMD_END:
            begin
                if (!res_full)
                begin
                    state_next = clear_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_HEAD:
            begin
                if (!res_full)
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                if (!res_full)
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (data_go && (rd_cnt_reg == lb_eff))
                begin
                    state_next = ST_TRAIL;
                end
            end
            ST_TRAIL:
            begin
                if (!res_full)
                begin
                    state_next = last_line ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop          = 1'b0;
        res_push       = 1'b0;
        res_entry      = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = pix_reg.addr;
        mem_raddr      = pix_reg.addr;
        mem_wdata      = pix_reg.on ? (rd_data_reg | bit_mask) : (rd_data_reg & ~bit_mask);
        init_next      = init_reg;
        sweep_cnt_next = sweep_cnt_reg;
        pol_next       = pol_reg;
        next_line_next = next_line_reg;
        line_next      = line_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_addr_next   = rd_addr_reg;
        pend_next      = pend_reg;
        clear_next     = clear_reg;
        cmd_byte_next  = cmd_byte_reg;
        pix_next       = pix_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we         = 1'b1;
                mem_waddr      = sweep_cnt_reg;
                mem_wdata      = BLANK_BYTE;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_done)
                begin
                    init_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    pix_next   = q_head;
                    line_next  = start_line;
                    clear_next = (q_head.op == MODE_CLEAR);
                    if (q_head.op == MODE_CLEAR)
                    begin
                        cmd_byte_next = CMD_CLEAR | (pol_reg ? CMD_VCOM : 8'h00);
                    end
                    else if (q_head.op == MODE_TOGGLE)
                    begin
                        pol_next      = !pol_reg;
                        cmd_byte_next = pol_reg ? 8'h00 : CMD_VCOM;
                    end
                end
            end
            ST_PIX_RD:
            begin
                mem_re = 1'b1;
            end
            ST_PIX_WR:
            begin
                mem_we = 1'b1;
            end
            ST_CMD:
            begin
                res_push       = 1'b1;
                res_entry.data = cmd_byte_reg;
            end
            ST_CMD_END:
            begin
                res_push       = 1'b1;
                res_entry.rel  = 1'b1;
                res_entry.last = 1'b1;
                sweep_cnt_next = '0;
            end
            ST_HEAD:
            begin
                res_push       = 1'b1;
                res_entry.data = CMD_WRITE;
            end
            ST_NUM:
            begin
                res_push       = 1'b1;
                res_entry.data = line_reg + 1'b1;
                rd_addr_next   = line_base[ADDR_W-1:0];
                rd_cnt_next    = '0;
                pend_next      = 1'b0;
            end
            ST_DATA:
            begin
                // hold the read register while a stalled byte waits
                res_push       = pend_reg;
                res_entry.data = rd_data_reg;
                mem_raddr      = rd_addr_reg;
                if (data_go)
                begin
                    if (rd_cnt_reg != lb_eff)
                    begin
                        mem_re       = 1'b1;
                        rd_addr_next = rd_addr_reg + 1'b1;
                        rd_cnt_next  = rd_cnt_reg + 1'b1;
                        pend_next    = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end
            ST_TRAIL:
            begin
                res_push       = 1'b1;
                res_entry.last = !last_line;
                if (!res_full)
                begin
                    next_line_next = last_line ? '0 : (line_reg + 1'b1);
                end
            end
            ST_FINAL:
            begin
                res_push       = 1'b1;
                res_entry.rel  = 1'b1;
                res_entry.last = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            init_reg      <= 1'b1;
            sweep_cnt_reg <= '0;
            pol_reg       <= 1'b0;
            next_line_reg <= '0;
            pend_reg      <= 1'b0;
            clear_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            sweep_cnt_reg <= sweep_cnt_next;
            pol_reg       <= pol_next;
            next_line_reg <= next_line_next;
            pend_reg      <= pend_next;
            clear_reg     <= clear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg     <= line_next;
        rd_cnt_reg   <= rd_cnt_next;
        rd_addr_reg  <= rd_addr_next;
        cmd_byte_reg <= cmd_byte_next;
        pix_reg      <= pix_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

@@ hw/rtl/memory_lcd_frame_serializer_core.sv @@
`timescale 1ns / 1ps
// Frame serializer for a monochrome memory LCD.
// Input queue: drive mode, x_pos, y_pos, pixel_on with push; the item is taken
// on a clock edge where push is high and full is low. Set-pixel items update
// the frame store and give no bytes; clear, toggle and draw items give bytes.
// Result queue: while empty is low, spi_byte, release_select and last show the
// oldest byte; pop takes it. last marks the final byte of each item.
// With the back end idle, a taken item passes the command queue and the back-end
// state register before its first byte is written into the result queue.
// The back end works on one item at a time. A draw item streams line_bytes
// bytes from the single frame-store read port after its dispatch and first
// read; set pixel reads, modifies and writes its store byte; toggle sends its
// bytes; clear sends its bytes and then a pass rewrites the store to 0xFF.
// Reset: full stays high while the store is blanked; VCOM and the line counter
// return to zero, line_bytes to 16 and line_count to 128.
// Writes on cfg_write/cfg_index/cfg_data take effect at once; write only when
// the block is idle. If pop is held low, up to four bytes wait in the result
// queue and two items in the command queue behind the one in progress, after
// which full rises; nothing is dropped.
module memory_lcd_frame_serializer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] mode,
    input  logic [8:0] x_pos,
    input  logic [7:0] y_pos,
    input  logic       pixel_on,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] spi_byte,
    output logic       release_select,
    output logic       last,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import mlfs_pkg::*;

    logic [5:0]        line_bytes_reg;
    logic [7:0]        line_count_reg;
    logic [LB_W-1:0]   lb_eff;
    logic [LINE_W-1:0] lc_eff;

    logic              q_push;
    cmd_t              q_wr_data;
    cmd_t              q_head;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              res_full;
    logic              res_push;
    res_t              res_entry;
    res_t              res_head;
    logic              init_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg <= 6'd16;
            line_count_reg <= 8'd128;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LINE_BYTES: line_bytes_reg <= cfg_data[5:0];
                REG_LINE_COUNT: line_count_reg <= cfg_data;
                default:        line_count_reg <= line_count_reg;
            endcase
        end
    end

    // saturate to store size, treat zero as one
    always_comb
    begin
        if (line_bytes_reg == 6'd0)
        begin
            lb_eff = LB_W'(1);
        end
        else if (line_bytes_reg > 6'(STORE_LINE_BYTES))
        begin
            lb_eff = LB_W'(STORE_LINE_BYTES);
        end
        else
        begin
            lb_eff = line_bytes_reg[LB_W-1:0];
        end
        if (line_count_reg == 8'd0)
        begin
            lc_eff = LINE_W'(1);
        end
        else if (line_count_reg > 8'(MAX_HEIGHT))
        begin
            lc_eff = LINE_W'(MAX_HEIGHT);
        end
        else
        begin
            lc_eff = line_count_reg;
        end
    end

    assign full = q_full || init_busy;

    mlfs_front u_front (
        .push     (push),
        .mode     (mode),
        .x_pos    (x_pos),
        .y_pos    (y_pos),
        .pixel_on (pixel_on),
        .lb_eff   (lb_eff),
        .lc_eff   (lc_eff),
        .stop     (full),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    mlfs_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    mlfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .lb_eff    (lb_eff),
        .lc_eff    (lc_eff),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_entry (res_entry),
        .init_busy (init_busy)
    );

    mlfs_res_fifo u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_entry),
        .rd_en   (pop),
        .rd_data (res_head),
        .f_full  (res_full),
        .f_empty (empty)
    );

    assign spi_byte       = res_head.data;
    assign release_select = res_head.rel;
    assign last           = res_head.last;

endmodule

@@ hw/rtl/mlfs_checker.sv @@
`timescale 1ns / 1ps
`include "memory_lcd_frame_serializer_core_defines.svh"
module mlfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] spi_byte,
    input logic       release_select,
    input logic       last
);

    // chip select only drops at the end of a transaction
    `MLFS_ASSERT_NOW(a_release_is_last, !empty && release_select, last, "release without last")

    // every closing byte is a zero trailer
    `MLFS_ASSERT_NOW(a_last_is_zero, !empty && last, spi_byte == 8'h00, "last byte not zero")

    `MLFS_ASSERT_NEXT(a_result_holds, !empty && !pop,
        !empty && $stable(spi_byte) && $stable(last) && $stable(release_select),
        "stalled result changed")

endmodule

bind memory_lcd_frame_serializer_core mlfs_checker u_mlfs_checker (.*);
